FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define CHK_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: src/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions of the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef logic [7:0][31:0] hash_t;   // index 0 is word a / H0

	localparam logic [31:0] PAD_WORD = 32'h8000_0000;

	function automatic hash_t init_hash();
		hash_t h;
		h[0] = 32'h6a09e667; h[1] = 32'hbb67ae85;
		h[2] = 32'h3c6ef372; h[3] = 32'ha54ff53a;
		h[4] = 32'h510e527f; h[5] = 32'h9b05688c;
		h[6] = 32'h1f83d9ab; h[7] = 32'h5be0cd19;
		return h;
	endfunction

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sched_word(input logic [31:0] wm16, input logic [31:0] wm15,
			input logic [31:0] wm7, input logic [31:0] wm2);
		logic [31:0] s0;
		logic [31:0] s1;
		s0 = ror(wm15, 7) ^ ror(wm15, 18) ^ (wm15 >> 3);
		s1 = ror(wm2, 17) ^ ror(wm2, 19) ^ (wm2 >> 10);
		return s1 + wm7 + s0 + wm16;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage

FILE: src/sha_round.sv
// ----------------------------------------------------------------------------
// sha_round
// One SHA-256 compression round on the eight working words.
// ----------------------------------------------------------------------------
module sha_round (
	input  sha_pkg::hash_t v,
	input  logic [31:0]    k,
	input  logic [31:0]    w,
	output sha_pkg::hash_t v_next
);

	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		t1 = v[7] + (sha_pkg::ror(v[4], 6) ^ sha_pkg::ror(v[4], 11) ^ sha_pkg::ror(v[4], 25))
			+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
		t2 = (sha_pkg::ror(v[0], 2) ^ sha_pkg::ror(v[0], 13) ^ sha_pkg::ror(v[0], 22))
			+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
		v_next[7] = v[6];
		v_next[6] = v[5];
		v_next[5] = v[4];
		v_next[4] = v[3] + t1;
		v_next[3] = v[2];
		v_next[2] = v[1];
		v_next[1] = v[0];
		v_next[0] = t1 + t2;
	end

endmodule

FILE: src/sha256_hash_engine_top.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_top
// SHA-256 engine: streamed message words in, eight digest words out.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per 32-bit big-endian message word. s_tlast
// marks the final word, whose valid_bytes (0..4) gives the leading bytes used.
// Output channel m_*: after the final word the eight digest words come out in
// order, word_index 0..7, m_tlast on the last one.
// Words land in a 16-entry block buffer memory. The sixteenth word of a block
// starts a compression (a step loading the working words and the first memory
// read, 64 rounds at one per cycle, one chaining update), during which
// s_tready is low. The final item adds padding pushes (one per cycle while no
// compression runs, up to 18, plus a step without a push to end the zero
// fill), one or two compressions, then eight result items.
// Reset loads the initial hash value and clears byte count and fill.
// A stalled receiver holds the current digest word; no input is taken until
// all eight result items are delivered.
// ----------------------------------------------------------------------------
module sha256_hash_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] valid_bytes, zero fill
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
	output logic        m_tlast    // last_word
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PAD  = 2'd1;
	localparam logic [1:0] ST_COMP = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	localparam logic [2:0] PH_DATA = 3'd0;
	localparam logic [2:0] PH_PADW = 3'd1;
	localparam logic [2:0] PH_ZERO = 3'd2;
	localparam logic [2:0] PH_LENH = 3'd3;
	localparam logic [2:0] PH_LENL = 3'd4;

	logic [1:0]  state_q;
	logic [1:0]  ret_q;
	logic [2:0]  ph_q;
	logic [3:0]  fill_q;
	logic [63:0] msg_q;
	logic [6:0]  rc_q;
	logic [2:0]  oidx_q;
	logic [31:0] data_q;
	logic [31:0] padw_q;
	sha_pkg::hash_t cv_q;
	sha_pkg::hash_t v_q;
	sha_pkg::hash_t v_next;
	logic [15:0][31:0] win_q;

	logic [31:0] mem [16];
	logic [31:0] rd_q;
	logic        wr_en;
	logic [31:0] wr_data;

	logic        in_acc;
	logic        out_acc;
	logic [2:0]  nb;
	logic [31:0] keep;
	logic [31:0] padbit;
	logic [63:0] len_bits;
	logic [31:0] w_cur;
	logic [31:0] k_cur;
	logic [5:0]  t_idx;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {5'd0, oidx_q, cv_q[oidx_q]};
	assign m_tlast  = (oidx_q == 3'd7);

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	assign nb       = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
	assign len_bits = {msg_q[60:0], 3'b000};
	assign t_idx    = 6'(rc_q - 7'd1);
	assign k_cur    = sha_pkg::round_k(t_idx);
	assign w_cur    = (rc_q <= 7'd16) ? rd_q
		: sha_pkg::sched_word(win_q[0], win_q[1], win_q[9], win_q[14]);

	always_comb begin
		case (nb)
			3'd0: begin keep = 32'h0000_0000; padbit = 32'h8000_0000; end
			3'd1: begin keep = 32'hff00_0000; padbit = 32'h0080_0000; end
			3'd2: begin keep = 32'hffff_0000; padbit = 32'h0000_8000; end
			3'd3: begin keep = 32'hffff_ff00; padbit = 32'h0000_0080; end
			default: begin keep = 32'hffff_ffff; padbit = 32'h0000_0000; end
		endcase
	end

	// pick the word pushed into the block buffer this cycle
	always_comb begin
		wr_en   = 1'b0;
		wr_data = '0;
		case (state_q)
			ST_IDLE: begin
				wr_en   = in_acc && !s_tlast;
				wr_data = s_tdata[31:0];
			end
			ST_PAD: begin
				case (ph_q)
					PH_DATA: begin wr_en = 1'b1; wr_data = data_q; end
					PH_PADW: begin wr_en = 1'b1; wr_data = padw_q; end
					PH_ZERO: begin wr_en = (fill_q != 4'd14); wr_data = '0; end
					PH_LENH: begin wr_en = 1'b1; wr_data = len_bits[63:32]; end
					PH_LENL: begin wr_en = 1'b1; wr_data = len_bits[31:0]; end
					default: begin wr_en = 1'b0; wr_data = '0; end
				endcase
			end
			default: begin
				wr_en   = 1'b0;
				wr_data = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q] <= wr_data;
		end
		rd_q <= mem[rc_q[3:0]];
	end

	sha_round u_round (
		.v      (v_q),
		.k      (k_cur),
		.w      (w_cur),
		.v_next (v_next)
	);

	// payload: working words and schedule window
	always_ff @(posedge clk) begin
		if (state_q == ST_COMP) begin
			if (rc_q == 7'd0) begin
				v_q <= cv_q;
			end else if (rc_q <= 7'd64) begin
				v_q <= v_next;
				for (int i = 0; i < 15; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[15] <= w_cur;
			end
		end
		if (in_acc && s_tlast) begin
			data_q <= s_tdata[31:0];
			padw_q <= (nb == 3'd4) ? sha_pkg::PAD_WORD : ((s_tdata[31:0] & keep) | padbit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			ph_q    <= PH_DATA;
			fill_q  <= '0;
			msg_q   <= '0;
			rc_q    <= '0;
			oidx_q  <= '0;
			cv_q    <= sha_pkg::init_hash();
		end else begin
			// advance fill on every push, compress on the sixteenth word
			if (wr_en) begin
				fill_q <= fill_q + 4'd1;
				if (fill_q == 4'd15) begin
					rc_q    <= '0;
					state_q <= ST_COMP;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tlast) begin
							msg_q   <= msg_q + 64'(nb);
							ph_q    <= (nb == 3'd4) ? PH_DATA : PH_PADW;
							state_q <= ST_PAD;
						end else begin
							msg_q <= msg_q + 64'd4;
							ret_q <= ST_IDLE;
						end
					end
				end
				ST_PAD: begin
					ret_q <= (ph_q == PH_LENL) ? ST_OUT : ST_PAD;
					case (ph_q)
						PH_DATA: ph_q <= PH_PADW;
						PH_PADW: ph_q <= PH_ZERO;
						PH_ZERO: if (fill_q == 4'd14) begin ph_q <= PH_LENH; end
						PH_LENH: ph_q <= PH_LENL;
						default: ph_q <= PH_LENL;
					endcase
				end
				ST_COMP: begin
					rc_q <= rc_q + 7'd1;
					if (rc_q == 7'd65) begin
						for (int i = 0; i < 8; i++) begin
							cv_q[i] <= cv_q[i] + v_q[i];
						end
						oidx_q  <= '0;
						state_q <= ret_q;
					end
				end
				default: begin
					if (out_acc) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							cv_q    <= sha_pkg::init_hash();
							msg_q   <= '0;
							fill_q  <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

endmodule

FILE: src/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the SHA-256 engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// input is never taken while digest words are pending
	`CHK_NEVER(a_no_overlap, clk, arst_n, s_tready && m_tvalid, "input open during output")

	`CHK_ASSERT(a_tlast_idx, clk, arst_n, m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)),
		"tlast does not match word index")

	`CHK_ASSERT(a_idx_step, clk, arst_n, (m_tvalid && m_tready && !m_tlast) |=>
		(m_tvalid && (m_tdata[34:32] == 3'($past(m_tdata[34:32]) + 3'd1))),
		"digest word index not consecutive")

	`CHK_ASSERT(a_last_in_busy, clk, arst_n, (s_tvalid && s_tready && s_tlast) |=> !s_tready,
		"ready right after final input word")

	`CHK_ASSERT(a_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
		"stalled output changed")

endmodule

bind sha256_hash_engine_top sha_checker u_sha_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: tb/tb_sha256_hash_engine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha256_hash_engine_top
// Streams byte messages into the SHA-256 engine and checks each digest word
// against a behavioral hash of the same message built inside the bench.
// ----------------------------------------------------------------------------
module tb_sha256_hash_engine_top;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	sha256_hash_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_item_t;

	// hash state of the message in flight
	sha_pkg::hash_t chain;
	logic [31:0] blk [16];
	int          fill;
	logic [63:0] msg_bytes;

	digest_item_t digest_q[$];

	int send_idle_pct;
	int recv_idle_pct;
	bit recv_hold;
	int n_sent;
	int n_digests;
	int n_words;
	int n_errors;
	int idle_cycles;

	localparam int WATCHDOG_LIMIT = 20000;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		logic [31:0] kk [64];
		kk = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				w[i] = blk[i];
			end else begin
				s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = s1 + w[i-7] + s0 + w[i-16];
			end
		end
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + kk[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endtask

	task automatic load_word(input logic [31:0] word);
		blk[fill] = word;
		fill++;
		if (fill == 16) begin
			compress();
			fill = 0;
		end
	endtask

	// fold one accepted item into the running hash; a final item queues the digest
	task automatic absorb_item(input logic [31:0] word, input logic [2:0] nb, input logic eom);
		int          n;
		logic [31:0] keep;
		logic [63:0] bitlen;
		digest_item_t item;
		if (!eom) begin
			msg_bytes += 4;
			load_word(word);
		end else begin
			n = (nb > 4) ? 4 : nb;
			msg_bytes += n;
			bitlen = msg_bytes << 3;
			if (n == 4) begin
				load_word(word);
				load_word(sha_pkg::PAD_WORD);
			end else begin
				keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
				load_word((word & keep) | (sha_pkg::PAD_WORD >> (8 * n)));
			end
			while (fill != 14) load_word(32'h0);
			load_word(bitlen[63:32]);
			load_word(bitlen[31:0]);
			for (int i = 0; i < 8; i++) begin
				item.word = chain[i];
				item.index = 3'(i);
				item.last = (i == 7);
				digest_q.push_back(item);
			end
			chain = sha_pkg::init_hash();
			fill = 0;
			msg_bytes = '0;
		end
	endtask

	task automatic send_item(input logic [31:0] word, input logic [2:0] nb, input logic eom);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {5'b0, nb, word};
		s_tlast = eom;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		absorb_item(word, nb, eom);
		n_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_message(input int nwords, input logic [2:0] tail_bytes);
		for (int i = 0; i < nwords - 1; i++) send_item($urandom, 3'($urandom_range(7)), 1'b0);
		send_item($urandom, tail_bytes, 1'b1);
	endtask

	task automatic wait_drained();
		while (digest_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// digest checker
	always @(posedge clk) begin
		digest_item_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[31:0], m_tdata[34:32], m_tlast};
			n_words++;
			if (digest_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("unexpected digest word %h", got.word);
			end else begin
				want = digest_q.pop_front();
				if (got.last) n_digests++;
				if (got !== want || m_tdata[39:35] !== 5'b0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
							want.word, want.index, want.last, got.word, got.index, got.last);
				end
			end
		end
	end

	// receiver backpressure
	always @(negedge clk) begin
		if (recv_hold) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sha256_hash_engine_top test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic test_directed();
		// empty message, every tail length, the block-boundary lengths
		send_item(32'hffff_ffff, 3'd0, 1'b1);
		for (int nb = 1; nb <= 7; nb++) send_item(32'hffff_ffff, 3'(nb), 1'b1);
		send_item(32'h6162_6300, 3'd3, 1'b1);
		send_item(32'h0000_0000, 3'd4, 1'b1);
		send_message(14, 3'd1);
		send_message(14, 3'd4);
		send_message(16, 3'd4);
		send_message(17, 3'd2);
	endtask

	task automatic test_random(input int count);
		int nw;
		int target;
		target = n_sent + count;
		while (n_sent < target) begin
			// mostly short messages, a few spanning several blocks
			nw = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 18);
			send_message(nw, 3'($urandom_range(7)));
		end
	endtask

	task automatic test_backpressure();
		recv_hold = 1'b1;
		fork
			begin
				send_message(20, 3'd3);
				send_message(3, 3'd4);
			end
			begin
				repeat (400) @(negedge clk);
				recv_hold = 1'b0;
			end
		join
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		recv_hold = 1'b0;
		send_idle_pct = 30;
		recv_idle_pct = 49;
		n_sent = 0; n_digests = 0; n_words = 0; n_errors = 0; idle_cycles = 0;
		chain = sha_pkg::init_hash();
		fill = 0;
		msg_bytes = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		wait_drained();
		test_random(90);
		send_idle_pct = 49;
		recv_idle_pct = 30;
		test_random(90);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(90);
		test_backpressure();
		wait_drained();

		$display("Sent %0d message words; checked %0d digest words over %0d digests.",
			n_sent, n_words, n_digests);
		$display("Covered empty and short tails, two-block padding and receiver stalls.");
		if (n_errors == 0 && digest_q.size() == 0) begin
			$display("sha256_hash_engine_top test passed");
		end else begin
			$display("sha256_hash_engine_top test failed");
		end
		$finish;
	end

endmodule
